// ----- sv/cfd_pkg.sv -----
// Shared constants, register indexes and lookup tables for the crossfading feedback delay.
// Used by the top level, cfd_div and cfd_fbpath; depends on nothing.
package cfd_pkg;

	localparam int DEF_STORE_DEPTH         = 65536;
	localparam int DEF_SAMPLE_BITS         = 24;
	localparam int DEF_DELAY_FRACTION_BITS = 8;

	localparam int REQ_BITS   = 24;
	localparam int MAXD_BITS  = 16;
	localparam int LEN_BITS   = 16;
	localparam int COEF_BITS  = 15;
	localparam int PHASE_BITS = 21;
	localparam int QUOT_BITS  = PHASE_BITS + 1;
	localparam int LUT_BITS   = 16;
	localparam int PADDR_BITS = 5;

	localparam logic [2:0] REG_FEEDBACK_GAIN    = 3'd0;
	localparam logic [2:0] REG_CROSSFADE_LENGTH = 3'd1;
	localparam logic [2:0] REG_DC_POLE          = 3'd2;
	localparam logic [2:0] REG_MAX_DELAY        = 3'd3;
	localparam logic [2:0] REG_INITIAL_DELAY    = 3'd4;

	localparam logic [COEF_BITS-1:0] GAIN_MAX  = 15'd24576;
	localparam logic [COEF_BITS-1:0] POLE_MAX  = 15'd32764;
	localparam logic [COEF_BITS-1:0] RST_POLE  = 15'd32604;
	localparam logic [LEN_BITS-1:0]  RST_LEN   = 16'd256;
	localparam logic [MAXD_BITS-1:0] RST_MAXD  = 16'd65534;
	localparam logic [REQ_BITS-1:0]  RST_INIT  = 24'd256;

	function automatic logic [LUT_BITS-1:0] sine_lut(input logic [5:0] k);
		logic [LUT_BITS-1:0] v;
		unique case (k)
			6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;
			6'd3: v = 16'd4808;   6'd4: v = 16'd6393;   6'd5: v = 16'd7962;
			6'd6: v = 16'd9512;   6'd7: v = 16'd11039;  6'd8: v = 16'd12540;
			6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
			6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
			6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
			6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27245;
			6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
			6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357;
			6'd27: v = 16'd31786; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
			6'd30: v = 16'd32610; 6'd31: v = 16'd32729; 6'd32: v = 16'd32768;
			default: v = 16'd32768;
		endcase
		return v;
	endfunction

	function automatic logic [LUT_BITS-1:0] tanh_lut(input logic [5:0] k);
		logic [LUT_BITS-1:0] v;
		unique case (k)
			6'd0: v = 16'd0;      6'd1: v = 16'd4075;   6'd2: v = 16'd8026;
			6'd3: v = 16'd11743;  6'd4: v = 16'd15143;  6'd5: v = 16'd18173;
			6'd6: v = 16'd20813;  6'd7: v = 16'd23066;  6'd8: v = 16'd24956;
			6'd9: v = 16'd26519;  6'd10: v = 16'd27797; 6'd11: v = 16'd28830;
			6'd12: v = 16'd29660; 6'd13: v = 16'd30322; 6'd14: v = 16'd30847;
			6'd15: v = 16'd31262; 6'd16: v = 16'd31589; 6'd17: v = 16'd31846;
			6'd18: v = 16'd32048; 6'd19: v = 16'd32206; 6'd20: v = 16'd32329;
			6'd21: v = 16'd32426; 6'd22: v = 16'd32501; 6'd23: v = 16'd32560;
			6'd24: v = 16'd32606; 6'd25: v = 16'd32642; 6'd26: v = 16'd32670;
			6'd27: v = 16'd32691; 6'd28: v = 16'd32708; 6'd29: v = 16'd32722;
			6'd30: v = 16'd32732; 6'd31: v = 16'd32740; 6'd32: v = 16'd32746;
			default: v = 16'd32746;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/crossfading_feedback_delay.sv -----
// Crossfading fractional feedback delay line, top level with sequencer and sample store.
// Each accepted transaction runs through the sequencer states in turn; during a fade it also
// waits in ST_INTS for the 22-step phase divider. One transaction is in work at a time, so a
// new one is taken only after the last has been written, and output stalls hold it in ST_WR.
// After reset the store is cleared to zero before the first input is taken.
// Depends on cfd_pkg, cfd_ram, cfd_div and cfd_fbpath.
module crossfading_feedback_delay import cfd_pkg::*; #(
	parameter int STORE_DEPTH         = DEF_STORE_DEPTH,
	parameter int SAMPLE_BITS         = DEF_SAMPLE_BITS,
	parameter int DELAY_FRACTION_BITS = DEF_DELAY_FRACTION_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// sample_in, delay_request
	input  logic [((SAMPLE_BITS+REQ_BITS+7)/8)*8-1:0]  s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// delayed_sample
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_tdata,
	// crossfading
	output logic                                       m_tuser,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic [PADDR_BITS-1:0]                      paddr,
	input  logic [31:0]                                pwdata,
	output logic [31:0]                                prdata,
	output logic                                       pready
);

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = DELAY_FRACTION_BITS;
	localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int DW  = MAXD_BITS + F;
	localparam int CW  = (DW > REQ_BITS) ? DW : REQ_BITS;
	localparam int MW  = (AW > MAXD_BITS) ? AW : MAXD_BITS;
	localparam int IDW = MW + 1;
	localparam int OUT_W = ((SB + 7) / 8) * 8;
	localparam longint MAX_M = (65534 < STORE_DEPTH - 1) ? 65534 : STORE_DEPTH - 1;
	localparam longint LO_D  = longint'(1) << F;
	localparam longint HI_D  = MAX_M << F;
	localparam longint RST_D = (256 < LO_D) ? LO_D : ((256 > HI_D) ? HI_D : 256);
	localparam logic [DW-1:0] RST_DLY   = DW'(RST_D);
	localparam logic [DW-1:0] FRAC_MASK = DW'((longint'(1) << F) - 1);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CTRL  = 4'd2;
	localparam logic [3:0] ST_ADDR  = 4'd3;
	localparam logic [3:0] ST_READ  = 4'd4;
	localparam logic [3:0] ST_INTP  = 4'd5;
	localparam logic [3:0] ST_INTS  = 4'd6;
	localparam logic [3:0] ST_WGT   = 4'd7;
	localparam logic [3:0] ST_MIX   = 4'd8;
	localparam logic [3:0] ST_BLEND = 4'd9;
	localparam logic [3:0] ST_FBGO  = 4'd10;
	localparam logic [3:0] ST_FB    = 4'd11;
	localparam logic [3:0] ST_WR    = 4'd12;

	typedef struct packed {
		logic [AW-1:0] i0;
		logic [AW-1:0] i1;
		logic [F:0]    fr;
	} tap_t;

	typedef struct packed {
		logic [LUT_BITS-1:0] base;
		logic [31:0]         prod;
	} wgt_t;

	logic [3:0]            state_q;
	logic [COEF_BITS-1:0]  gain_q, pole_q;
	logic [LEN_BITS-1:0]   xlen_q;
	logic [MAXD_BITS-1:0]  maxd_q;
	logic [REQ_BITS-1:0]   init_q;
	logic [DW-1:0]         active_q, prev_q, target_q, nd_q;
	logic [LEN_BITS-1:0]   fp_q;
	logic                  fading_q;
	logic [AW-1:0]         wp_q, clr_q;
	logic [SB-1:0]         sample_q;
	tap_t                  tap_a_q, tap_b_q;
	logic [2:0]            rd_cnt_q;
	logic [SB-1:0]         sbuf_q [4];
	logic signed [SB+F+2:0] pa_q, pb_q;
	logic [SB-1:0]         ta_q, tb_q;
	wgt_t                  wn_q, wo_q;
	logic signed [SB+16:0] mo_q, mn_q;
	logic [SB-1:0]         delayed_q;
	logic                  fade_out_q;
	logic                  out_valid_q;
	logic [SB-1:0]         out_data_q;
	logic                  out_fade_q;

	logic [LEN_BITS-1:0]   len;
	logic [COEF_BITS-1:0]  gain_eff, pole_eff;
	logic                  in_fire, cfg_wr, commit;
	logic [SB-1:0]         in_sample;
	logic [REQ_BITS-1:0]   in_req;
	logic [DW-1:0]         act1;
	logic [1:0]            rd_idx;
	logic [AW-1:0]         raddr, waddr;
	logic                  we;
	logic [SB-1:0]         wdata, rdata;
	logic                  div_done;
	logic [QUOT_BITS-1:0]  phase;
	logic [QUOT_BITS-1:0]  phase_old;
	logic [LUT_BITS:0]     wn, wo;
	logic signed [SB+17:0] bsum;
	logic signed [SB+17:0] bsh;
	logic [SB-1:0]         blend;
	logic signed [SB+F+2:0] ta_full, tb_full;
	logic                  fb_done;
	logic [SB-1:0]         fb_sum;

	function automatic logic [DW-1:0] clamp_dly(input logic [REQ_BITS-1:0] d,
	                                            input logic [MAXD_BITS-1:0] mx);
		logic [MW-1:0] m;
		logic [CW-1:0] hi, lo, dx, r;
		m = (mx == '0) ? MW'(1) : MW'(mx);
		if (m > MW'(STORE_DEPTH - 1)) begin
			m = MW'(STORE_DEPTH - 1);
		end
		hi = CW'(m) << F;
		lo = CW'(1) << F;
		dx = CW'(d);
		r  = (dx < lo) ? lo : ((dx > hi) ? hi : dx);
		return DW'(r);
	endfunction

	function automatic tap_t make_tap(input logic [DW-1:0] d, input logic [AW-1:0] wp);
		tap_t           t;
		logic [DW-1:0]  frac;
		logic [IDW-1:0] back, diff;
		frac = d & FRAC_MASK;
		back = IDW'(d >> F) + IDW'(frac != '0);
		if (IDW'(wp) >= back) begin
			diff = IDW'(wp) - back;
		end else begin
			diff = IDW'(wp) + IDW'(STORE_DEPTH) - back;
		end
		t.i0 = diff[AW-1:0];
		t.i1 = (t.i0 == AW'(STORE_DEPTH - 1)) ? '0 : t.i0 + AW'(1);
		t.fr = (frac == '0) ? '0 : (F+1)'(longint'(1) << F) - (F+1)'(frac);
		return t;
	endfunction

	function automatic wgt_t make_wgt(input logic [QUOT_BITS-1:0] t);
		wgt_t                w;
		logic [5:0]          seg;
		logic [LUT_BITS-1:0] a, b;
		seg = t[QUOT_BITS-1:16];
		if (seg >= 6'd32) begin
			a = sine_lut(6'd32);
			b = a;
		end else begin
			a = sine_lut(seg);
			b = sine_lut(seg + 6'd1);
		end
		w.base = a;
		w.prod = 32'(b - a) * 32'(t[15:0]);
		return w;
	endfunction

	assign len      = (xlen_q == '0) ? LEN_BITS'(1) : xlen_q;
	assign gain_eff = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
	assign pole_eff = (pole_q > POLE_MAX) ? POLE_MAX : pole_q;

	assign in_sample = s_tdata[SB-1:0];
	assign in_req    = s_tdata[SB+REQ_BITS-1:SB];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign commit    = (state_q == ST_WR) && (!out_valid_q || m_tready);

	assign act1   = (fp_q >= len) ? target_q : active_q;
	assign rd_idx = 2'(rd_cnt_q - 3'd1);

	always_comb begin
		unique case (rd_cnt_q[1:0])
			2'd0: raddr = tap_a_q.i0;
			2'd1: raddr = tap_a_q.i1;
			2'd2: raddr = tap_b_q.i0;
			2'd3: raddr = tap_b_q.i1;
			default: raddr = tap_a_q.i0;
		endcase
	end

	assign we    = (state_q == ST_CLR) || commit;
	assign waddr = (state_q == ST_CLR) ? clr_q : wp_q;
	assign wdata = (state_q == ST_CLR) ? '0 : fb_sum;

	assign phase_old = QUOT_BITS'(longint'(1) << PHASE_BITS) - phase;

	always_comb begin
		ta_full = (SB+F+3)'($signed(sbuf_q[0])) + (pa_q >>> F);
		tb_full = (SB+F+3)'($signed(sbuf_q[2])) + (pb_q >>> F);
		wn      = (LUT_BITS+1)'(wn_q.base) + (LUT_BITS+1)'(wn_q.prod[31:16]);
		wo      = (LUT_BITS+1)'(wo_q.base) + (LUT_BITS+1)'(wo_q.prod[31:16]);
		bsum    = (SB+18)'(mo_q) + (SB+18)'(mn_q);
		bsh     = bsum >>> 15;
		if (&bsh[SB+17:SB-1] || ~|bsh[SB+17:SB-1]) begin
			blend = bsh[SB-1:0];
		end else if (bsh[SB+17]) begin
			blend = {1'b1, {(SB-1){1'b0}}};
		end else begin
			blend = {1'b0, {(SB-1){1'b1}}};
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_FEEDBACK_GAIN:    prdata = 32'(gain_q);
			REG_CROSSFADE_LENGTH: prdata = 32'(xlen_q);
			REG_DC_POLE:          prdata = 32'(pole_q);
			REG_MAX_DELAY:        prdata = 32'(maxd_q);
			REG_INITIAL_DELAY:    prdata = 32'(init_q);
			default:              prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			gain_q      <= '0;
			xlen_q      <= RST_LEN;
			pole_q      <= RST_POLE;
			maxd_q      <= RST_MAXD;
			init_q      <= RST_INIT;
			active_q    <= RST_DLY;
			prev_q      <= RST_DLY;
			target_q    <= RST_DLY;
			fp_q        <= RST_LEN;
			fading_q    <= 1'b0;
			wp_q        <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_FEEDBACK_GAIN:    gain_q <= pwdata[COEF_BITS-1:0];
					REG_CROSSFADE_LENGTH: xlen_q <= pwdata[LEN_BITS-1:0];
					REG_DC_POLE:          pole_q <= pwdata[COEF_BITS-1:0];
					REG_MAX_DELAY:        maxd_q <= pwdata[MAXD_BITS-1:0];
					REG_INITIAL_DELAY: begin
						init_q   <= pwdata[REQ_BITS-1:0];
						active_q <= clamp_dly(pwdata[REQ_BITS-1:0], maxd_q);
						prev_q   <= clamp_dly(pwdata[REQ_BITS-1:0], maxd_q);
						target_q <= clamp_dly(pwdata[REQ_BITS-1:0], maxd_q);
						fp_q     <= len;
					end
					default: begin
					end
				endcase
			end

			out_valid_q <= commit || (out_valid_q && !m_tready);
			if (commit) begin
				wp_q <= (wp_q == AW'(STORE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end

			unique case (state_q)
				ST_CLR: begin
					if (clr_q == AW'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CTRL;
					end
				end
				ST_CTRL: begin
					active_q <= act1;
					if (nd_q != target_q) begin
						prev_q   <= act1;
						target_q <= nd_q;
						fp_q     <= '0;
						fading_q <= 1'b1;
					end else begin
						fading_q <= fp_q < len;
					end
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4) begin
						state_q <= ST_INTP;
					end
				end
				ST_INTP: state_q <= ST_INTS;
				ST_INTS: begin
					if (!fading_q || div_done) begin
						state_q <= ST_WGT;
					end
				end
				ST_WGT:  state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_BLEND;
				ST_BLEND: begin
					if (fading_q) begin
						fp_q <= fp_q + LEN_BITS'(1);
						if ((LEN_BITS+1)'(fp_q) + 1 >= (LEN_BITS+1)'(len)) begin
							active_q <= target_q;
						end
					end
					state_q <= ST_FBGO;
				end
				ST_FBGO: state_q <= ST_FB;
				ST_FB: begin
					if (fb_done) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= in_sample;
			nd_q     <= clamp_dly(in_req, maxd_q);
		end
		if (state_q == ST_ADDR) begin
			tap_a_q <= make_tap(fading_q ? prev_q : active_q, wp_q);
			tap_b_q <= make_tap(target_q, wp_q);
		end
		if (state_q == ST_READ && rd_cnt_q != 3'd0) begin
			sbuf_q[rd_idx] <= rdata;
		end
		if (state_q == ST_INTP) begin
			pa_q <= ($signed({sbuf_q[1][SB-1], sbuf_q[1]}) - $signed({sbuf_q[0][SB-1], sbuf_q[0]}))
			        * $signed({1'b0, tap_a_q.fr});
			pb_q <= ($signed({sbuf_q[3][SB-1], sbuf_q[3]}) - $signed({sbuf_q[2][SB-1], sbuf_q[2]}))
			        * $signed({1'b0, tap_b_q.fr});
		end
		if (state_q == ST_INTS) begin
			ta_q <= ta_full[SB-1:0];
			tb_q <= tb_full[SB-1:0];
		end
		if (state_q == ST_WGT) begin
			wn_q <= make_wgt(phase);
			wo_q <= make_wgt(phase_old);
		end
		if (state_q == ST_MIX) begin
			mo_q <= $signed(wo) * $signed(ta_q);
			mn_q <= $signed(wn) * $signed(tb_q);
		end
		if (state_q == ST_BLEND) begin
			delayed_q  <= fading_q ? blend : ta_q;
			fade_out_q <= fading_q && ((LEN_BITS+1)'(fp_q) + 1 < (LEN_BITS+1)'(len));
		end
		if (commit) begin
			out_data_q <= delayed_q;
			out_fade_q <= fade_out_q;
		end
	end

	cfd_ram #(
		.WIDTH (SB),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	cfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == ST_ADDR) && fading_q),
		.numer  ((LEN_BITS+1)'(fp_q) + (LEN_BITS+1)'(1)),
		.denom  (len),
		.done   (div_done),
		.quot   (phase)
	);

	cfd_fbpath #(
		.SAMPLE_BITS (SB)
	) u_fbpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_FBGO),
		.delayed (delayed_q),
		.sample  (sample_q),
		.gain    (gain_eff),
		.pole    (pole_eff),
		.done    (fb_done),
		.sum     (fb_sum)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);
	assign m_tuser  = out_fade_q;

endmodule

// ----- sv/cfd_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module cfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/cfd_div.sv -----
// Restoring divider producing the crossfade phase ((n << 21) / len), one quotient bit a cycle.
// Depends on cfd_pkg.
module cfd_div import cfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [LEN_BITS:0]    numer,
	input  logic [LEN_BITS-1:0]  denom,
	output logic                 done,
	output logic [QUOT_BITS-1:0] quot
);

	logic [LEN_BITS+1:0]  rem_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic [4:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 ge;
	logic [LEN_BITS+1:0]  rem_sub;

	assign ge      = rem_q >= (LEN_BITS+2)'(denom);
	assign rem_sub = ge ? rem_q - (LEN_BITS+2)'(denom) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'(QUOT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= (LEN_BITS+2)'(numer);
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= {rem_sub[LEN_BITS:0], 1'b0};
			quot_q <= {quot_q[QUOT_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- sv/cfd_fbpath.sv -----
// Feedback path: gain, DC blocker, tanh soft limiter and saturating sum with the input.
// Four pipeline stages; holds the DC blocker state. Depends on cfd_pkg.
module cfd_fbpath import cfd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] delayed,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [COEF_BITS-1:0]   gain,
	input  logic [COEF_BITS-1:0]   pole,
	output logic                   done,
	output logic [SAMPLE_BITS-1:0] sum
);

	localparam int SB = SAMPLE_BITS;
	localparam int YW = SB + 8;

	logic v1_q, v2_q, v3_q, v4_q;

	logic signed [SB+1:0]   fb_s1;
	logic signed [SB+23:0]  pd_s1;
	logic [SB-1:0]          sample_s1, sample_s2, sample_s3;
	logic signed [SB+1:0]   dc_in_q;
	logic signed [YW-1:0]   dc_out_q;
	logic signed [YW-1:0]   y_s2;
	logic [LUT_BITS-1:0]    base_s3;
	logic [31:0]            prod_s3;
	logic                   neg_s3;
	logic [SB-1:0]          sum_q;

	logic signed [SB+15:0]  fb_prod;
	logic signed [SB+10:0]  y_raw;
	logic signed [YW-1:0]   y_sat;
	logic [YW-1:0]          mag;
	logic [SB+26:0]         mag_sh;
	logic [SB+26:0]         u_full;
	logic [27:0]            u;
	logic [11:0]            seg;
	logic [LUT_BITS-1:0]    ta, tb;
	logic [LUT_BITS-1:0]    lut;
	logic [SB+14:0]         scaled;
	logic signed [SB:0]     lim;
	logic signed [SB+1:0]   total;

	assign fb_prod = $signed(delayed) * $signed({1'b0, gain});

	always_comb begin
		y_raw = (SB+11)'(fb_s1) - (SB+11)'(dc_in_q) + (SB+11)'(pd_s1 >>> 15);
		if (&y_raw[SB+10:YW-1] || ~|y_raw[SB+10:YW-1]) begin
			y_sat = y_raw[YW-1:0];
		end else if (y_raw[SB+10]) begin
			y_sat = {1'b1, {(YW-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(YW-1){1'b1}}};
		end
	end

	always_comb begin
		mag    = y_s2[YW-1] ? YW'(-y_s2) : YW'(y_s2);
		mag_sh = {mag, 19'b0};
		u_full = mag_sh >> (SB - 1);
		u      = u_full[27:0];
		seg    = u[27:16];
		if (seg >= 12'd32) begin
			ta = tanh_lut(6'd32);
			tb = ta;
		end else begin
			ta = tanh_lut(seg[5:0]);
			tb = tanh_lut(seg[5:0] + 6'd1);
		end
	end

	always_comb begin
		lut    = base_s3 + prod_s3[31:16];
		scaled = {lut, {(SB-1){1'b0}}} >> 15;
		lim    = neg_s3 ? -$signed({1'b0, scaled[SB-1:0]}) : $signed({1'b0, scaled[SB-1:0]});
		total  = (SB+2)'($signed(sample_s3)) + (SB+2)'(lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			v3_q     <= 1'b0;
			v4_q     <= 1'b0;
			dc_in_q  <= '0;
			dc_out_q <= '0;
		end else begin
			v1_q <= start;
			v2_q <= v1_q;
			v3_q <= v2_q;
			v4_q <= v3_q;
			if (v1_q) begin
				dc_in_q  <= fb_s1;
				dc_out_q <= y_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fb_s1     <= (SB+2)'(fb_prod >>> 14);
			pd_s1     <= $signed({1'b0, pole}) * dc_out_q;
			sample_s1 <= sample;
		end
		if (v1_q) begin
			y_s2      <= y_sat;
			sample_s2 <= sample_s1;
		end
		if (v2_q) begin
			base_s3   <= ta;
			prod_s3   <= 32'(tb - ta) * 32'(u[15:0]);
			neg_s3    <= y_s2[YW-1];
			sample_s3 <= sample_s2;
		end
		if (v3_q) begin
			if (&total[SB+1:SB-1] || ~|total[SB+1:SB-1]) begin
				sum_q <= total[SB-1:0];
			end else if (total[SB+1]) begin
				sum_q <= {1'b1, {(SB-1){1'b0}}};
			end else begin
				sum_q <= {1'b0, {(SB-1){1'b1}}};
			end
		end
	end

	assign done = v4_q;
	assign sum  = sum_q;

endmodule
